>>> hw/rtl/hsjc_pkg.sv
// ----------------------------------------------------------------------------
// Hard-stop joint calibrator package
// Shared types and constants: phases, register indexes, item and result
// records and the configuration record.
// ----------------------------------------------------------------------------
package hsjc_pkg;

  localparam int unsigned SpeedW   = 15;
  localparam int unsigned CurrentW = 16;
  localparam int unsigned TickW    = 16;
  localparam int unsigned CountW   = 3;
  localparam int unsigned PosW     = 32;
  localparam int unsigned DriveW   = 16;
  localparam int unsigned MotorW   = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [SpeedW-1:0]   SpeedReset   = 15'd70;
  localparam logic [CurrentW-1:0] LimitReset   = 16'd400;
  localparam logic [TickW-1:0]    SettleReset  = 16'd50;
  localparam logic [CountW-1:0]   MotorsReset  = 3'd3;
  localparam logic [CountW-1:0]   FinishedMax  = 3'd7;
  localparam logic [TickW-1:0]    TickMax      = 16'hFFFF;

  typedef enum logic [2:0] {
    PhSeekHigh = 3'd0,
    PhBackOff  = 3'd1,
    PhSeekLow  = 3'd2,
    PhFoundLow = 3'd3,
    PhDone     = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    RegDriveSpeed   = 2'd0,
    RegCurrentLimit = 2'd1,
    RegSettleTicks  = 2'd2,
    RegNumMotors    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CmdStart  = 1'b0,
    CmdSample = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [SpeedW-1:0]   drive_speed;
    logic [CurrentW-1:0] current_limit;
    logic [TickW-1:0]    settle_ticks;
    logic [CountW-1:0]   num_motors;
  } cfg_t;

  typedef struct packed {
    logic                   cmd;
    logic [MotorW-1:0]      motor_index;
    logic [CurrentW-1:0]    motor_current;
    logic signed [PosW-1:0] encoder_position;
  } item_t;

  typedef struct packed {
    logic [MotorW-1:0]        out_motor;
    logic                     drive_write;
    logic signed [DriveW-1:0] drive_value;
    logic signed [PosW-1:0]   max_position;
    logic signed [PosW-1:0]   min_position;
    logic [2:0]               motor_phase;
    logic                     all_done;
  } result_t;

endpackage

>>> hw/rtl/hsjc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Hard-stop joint calibrator configuration registers
// Holds drive speed, current limit, settle ticks and motor count.
// ----------------------------------------------------------------------------
module hsjc_cfg_regs
  import hsjc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_speed   <= SpeedReset;
      cfg_q.current_limit <= LimitReset;
      cfg_q.settle_ticks  <= SettleReset;
      cfg_q.num_motors    <= MotorsReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegDriveSpeed:   cfg_q.drive_speed   <= cfg_data_i[SpeedW-1:0];
        RegCurrentLimit: cfg_q.current_limit <= cfg_data_i[CurrentW-1:0];
        RegSettleTicks:  cfg_q.settle_ticks  <= cfg_data_i[TickW-1:0];
        RegNumMotors:    cfg_q.num_motors    <= cfg_data_i[CountW-1:0];
        default:         cfg_q <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/hsjc_engine.sv
// ----------------------------------------------------------------------------
// Hard-stop joint calibrator engine
// Per-motor phase, tick counter and latched stops, with the combinational
// update that turns one item into one result.
// ----------------------------------------------------------------------------
module hsjc_engine
  import hsjc_pkg::*;
#(
  parameter int unsigned MOTORS = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  localparam int unsigned IdxW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  phase_e                 phase_q [MOTORS];
  logic [TickW-1:0]       tick_q  [MOTORS];
  logic signed [PosW-1:0] upper_q [MOTORS];
  logic signed [PosW-1:0] lower_q [MOTORS];
  logic [CountW-1:0]      finished_q;

  logic [IdxW-1:0]        idx;
  logic                   in_range;
  phase_e                 phase_cur;
  logic [TickW-1:0]       tick_cur;
  logic                   settled;
  logic                   stop_seen;
  phase_e                 phase_d;
  logic [TickW-1:0]       tick_base;
  logic [TickW-1:0]       tick_d;
  logic signed [PosW-1:0] upper_d;
  logic signed [PosW-1:0] lower_d;
  logic [CountW-1:0]      finished_d;
  logic                   drive_write;
  logic [DriveW-1:0]      drive_value;
  logic [DriveW-1:0]      speed_ext;

  assign idx       = IdxW'(item_i.motor_index);
  assign in_range  = int'(item_i.motor_index) < int'(MOTORS);
  assign phase_cur = phase_q[idx];
  assign tick_cur  = tick_q[idx];
  assign settled   = tick_cur > cfg_i.settle_ticks;
  assign stop_seen = settled && (item_i.motor_current > cfg_i.current_limit);
  assign speed_ext = DriveW'(cfg_i.drive_speed);

  always_comb begin
    phase_d     = phase_cur;
    tick_base   = tick_cur;
    upper_d     = upper_q[idx];
    lower_d     = lower_q[idx];
    finished_d  = finished_q;
    drive_write = 1'b0;
    drive_value = '0;
    if (item_i.cmd == CmdStart) begin
      phase_d     = PhSeekHigh;
      tick_base   = '0;
      drive_write = 1'b1;
      drive_value = speed_ext;
    end else if (stop_seen) begin
      drive_write = 1'b1;
      if (phase_cur == PhSeekHigh) begin
        upper_d   = item_i.encoder_position;
        phase_d   = PhBackOff;
        tick_base = '0;
      end else if (phase_cur == PhSeekLow) begin
        lower_d = item_i.encoder_position;
        phase_d = PhFoundLow;
      end
    end else if (phase_cur == PhBackOff && settled) begin
      drive_write = 1'b1;
      drive_value = DriveW'(16'd0 - speed_ext);
      phase_d     = PhSeekLow;
      tick_base   = '0;
    end else if (phase_cur == PhFoundLow) begin
      if (finished_q != FinishedMax) begin
        finished_d = finished_q + CountW'(1);
      end
      phase_d = PhDone;
    end
    // Sample items advance the counter after the phase update; starts do not.
    if (item_i.cmd == CmdSample && tick_base != TickMax) begin
      tick_d = tick_base + TickW'(1);
    end else begin
      tick_d = tick_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MOTORS); i++) begin
        phase_q[i] <= PhSeekHigh;
        tick_q[i]  <= '0;
        upper_q[i] <= '0;
        lower_q[i] <= '0;
      end
      finished_q <= '0;
    end else if (fire_i && in_range) begin
      phase_q[idx] <= phase_d;
      tick_q[idx]  <= tick_d;
      upper_q[idx] <= upper_d;
      lower_q[idx] <= lower_d;
      finished_q   <= finished_d;
    end
  end

  always_comb begin
    result_o.out_motor = item_i.motor_index;
    if (in_range) begin
      result_o.drive_write  = drive_write;
      result_o.drive_value  = drive_value;
      result_o.max_position = upper_d;
      result_o.min_position = lower_d;
      result_o.motor_phase  = phase_d;
      result_o.all_done     = finished_d == cfg_i.num_motors;
    end else begin
      result_o.drive_write  = 1'b0;
      result_o.drive_value  = '0;
      result_o.max_position = '0;
      result_o.min_position = '0;
      result_o.motor_phase  = '0;
      result_o.all_done     = finished_q == cfg_i.num_motors;
    end
  end

endmodule

>>> hw/rtl/hard_stop_joint_calibrator_core.sv
// ----------------------------------------------------------------------------
// Hard-stop joint calibrator core
// Stream wrapper: input register, calibration engine, result register.
// ----------------------------------------------------------------------------
// Accepts one beat per clock while the output is not stalled and returns one
// result beat per input beat, through the input and result registers. The
// rate is set by the per-motor state, read, updated and written back as each
// beat leaves the input register; one motor's items may follow without gaps.
// Start beats (tuser 0) arm a motor and command +drive_speed; sample beats
// (tuser 1) carry current and encoder and walk the motor through seek high,
// back off, seek low, found low and done. Configuration writes are taken at
// any time but should only be issued while no beat is in flight.
module hard_stop_joint_calibrator_core
  import hsjc_pkg::*;
#(
  parameter int unsigned MOTORS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Fields from bit 0: motor_index[1:0], motor_current[17:2],
  // encoder_position[49:18], zero fill.
  input  logic [55:0]         s_axis_tdata,
  // Fields from bit 0: cmd.
  input  logic [0:0]          s_axis_tuser,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // Fields from bit 0: out_motor[1:0], drive_write[2], drive_value[18:3],
  // max_position[50:19], min_position[82:51], motor_phase[85:83],
  // all_done[86], zero fill.
  output logic [87:0]         m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t result;
  result_t result_q;
  logic    out_valid_q;
  logic    advance;
  logic    in_fire;

  assign cfg_ready_o = 1'b1;

  hsjc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The result register moves whenever it is empty or being drained.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.cmd              <= s_axis_tuser[0];
      item_q.motor_index      <= s_axis_tdata[1:0];
      item_q.motor_current    <= s_axis_tdata[17:2];
      item_q.encoder_position <= s_axis_tdata[49:18];
    end
  end

  hsjc_engine #(
    .MOTORS(MOTORS)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance && in_valid_q),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid        = out_valid_q;
  assign m_axis_tdata[1:0]    = result_q.out_motor;
  assign m_axis_tdata[2]      = result_q.drive_write;
  assign m_axis_tdata[18:3]   = result_q.drive_value;
  assign m_axis_tdata[50:19]  = result_q.max_position;
  assign m_axis_tdata[82:51]  = result_q.min_position;
  assign m_axis_tdata[85:83]  = result_q.motor_phase;
  assign m_axis_tdata[86]     = result_q.all_done;
  assign m_axis_tdata[87]     = 1'b0;

endmodule

>>> test/hard_stop_joint_calibrator_core_tb.sv
// ----------------------------------------------------------------------------
// Hard-stop joint calibrator core testbench
// Drives start and sample beats through the stream port and retunes the block
// between phases over the register port. Every result beat is checked field by
// field against an in-order queue, filled from typed rows or from a model of the
// motor phases, tick counters and latched stops; both sides idle at random.
// ----------------------------------------------------------------------------
module hard_stop_joint_calibrator_core_tb;
  import hsjc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumMotors  = 4;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 300;
  localparam result_t     NoWant     = '0;

  typedef struct {
    logic    retune;
    cfg_t    cfg;
    item_t   it;
    logic    typed;
    result_t want;
  } plan_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic [55:0]         s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [87:0]         m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // Model state of the calibration engine.
  cfg_t              cal_cfg;
  phase_e            mot_phase [NumMotors];
  logic [TickW-1:0]  mot_ticks [NumMotors];
  logic [PosW-1:0]   hi_stop   [NumMotors];
  logic [PosW-1:0]   lo_stop   [NumMotors];
  logic [CountW-1:0] done_count;

  result_t     pending [$];
  plan_row_t   plan [$];
  int unsigned fail_cnt      = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_asked    = 0;
  int unsigned hold_given    = 0;
  int unsigned hold_left     = 0;

  hard_stop_joint_calibrator_core #(
    .MOTORS(NumMotors)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void model_reset();
    cal_cfg    = '{SpeedReset, LimitReset, SettleReset, MotorsReset};
    done_count = '0;
    for (int i = 0; i < NumMotors; i++) begin
      mot_phase[i] = PhSeekHigh;
      mot_ticks[i] = '0;
      hi_stop[i]   = '0;
      lo_stop[i]   = '0;
    end
  endfunction

  // One calibration step for the motor an accepted beat names.
  function automatic result_t calib_step(item_t it);
    result_t           r;
    logic              settled;
    logic [MotorW-1:0] m;
    m = it.motor_index;
    r = '0;
    r.out_motor = it.motor_index;
    if (it.cmd == CmdStart) begin
      mot_phase[m]  = PhSeekHigh;
      mot_ticks[m]  = '0;
      r.drive_write = 1'b1;
      r.drive_value = {1'b0, cal_cfg.drive_speed};
    end else begin
      settled = mot_ticks[m] > cal_cfg.settle_ticks;
      if (it.motor_current > cal_cfg.current_limit && settled) begin
        r.drive_write = 1'b1;
        if (mot_phase[m] == PhSeekHigh) begin
          hi_stop[m]   = it.encoder_position;
          mot_phase[m] = PhBackOff;
          mot_ticks[m] = '0;
        end else if (mot_phase[m] == PhSeekLow) begin
          lo_stop[m]   = it.encoder_position;
          mot_phase[m] = PhFoundLow;
        end
      end else if (mot_phase[m] == PhBackOff && settled) begin
        r.drive_write = 1'b1;
        r.drive_value = -signed'({1'b0, cal_cfg.drive_speed});
        mot_phase[m]  = PhSeekLow;
        mot_ticks[m]  = '0;
      end else if (mot_phase[m] == PhFoundLow) begin
        if (done_count != FinishedMax) done_count = done_count + 1'b1;
        mot_phase[m] = PhDone;
      end
      if (mot_ticks[m] != TickMax) mot_ticks[m] = mot_ticks[m] + 1'b1;
    end
    r.max_position = hi_stop[m];
    r.min_position = lo_stop[m];
    r.motor_phase  = mot_phase[m];
    r.all_done     = (done_count == cal_cfg.num_motors);
    return r;
  endfunction

  function automatic void add_row(logic rt, cfg_t c, cmd_e cmd, logic [1:0] m,
                                  logic [15:0] cur, logic [31:0] enc,
                                  logic typed, result_t want);
    plan_row_t row;
    row.retune = rt;
    row.cfg    = c;
    row.it     = '{cmd, m, cur, enc};
    row.typed  = typed;
    row.want   = want;
    plan.push_back(row);
  endfunction

  // Random beats lean on the current limit so that stops are both hit and
  // missed; a few beats ignore it entirely.
  function automatic item_t rand_item();
    item_t       it;
    int unsigned pick;
    it.cmd              = ($urandom_range(99) < 5) ? CmdStart : CmdSample;
    it.motor_index      = MotorW'($urandom_range(NumMotors - 1));
    it.encoder_position = $urandom;
    pick = $urandom_range(99);
    if (pick < 10 || cal_cfg.current_limit == 16'hFFFF) begin
      it.motor_current = CurrentW'($urandom);
    end else if (pick < 55) begin
      it.motor_current = CurrentW'($urandom_range(32'hFFFF, cal_cfg.current_limit + 1));
    end else begin
      it.motor_current = CurrentW'($urandom_range(cal_cfg.current_limit, 0));
    end
    return it;
  endfunction

  function automatic void field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
    end
  endfunction

  task automatic check_beat(logic [87:0] data);
    result_t want;
    if (pending.size() == 0) begin
      fail_cnt++;
      $display("%0t: unexpected result beat, expected none, got %h", $realtime, data);
    end else begin
      want = pending.pop_front();
      field_ok("out_motor", 32'(want.out_motor), 32'(data[1:0]));
      field_ok("drive_write", 32'(want.drive_write), 32'(data[2]));
      field_ok("drive_value", 32'(unsigned'(want.drive_value)), 32'(data[18:3]));
      field_ok("max_position", want.max_position, data[50:19]);
      field_ok("min_position", want.min_position, data[82:51]);
      field_ok("motor_phase", 32'(want.motor_phase), 32'(data[85:83]));
      field_ok("all_done", 32'(want.all_done), 32'(data[86]));
    end
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: checks beats and decides tready, with long hold-offs on request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_beat(m_axis_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_asked > hold_given) begin
        hold_given++;
        hold_left = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_item(item_t it, logic typed, result_t want);
    result_t calc;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {6'd0, it.encoder_position, it.motor_current, it.motor_index};
    do @(posedge clk_i); while (!s_axis_tready);
    calc = calib_step(it);
    pending.push_back(typed ? want : calc);
  endtask

  // Stops the source and waits until every expected result beat has been checked.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegDriveSpeed:   cal_cfg.drive_speed   = data[SpeedW-1:0];
      RegCurrentLimit: cal_cfg.current_limit = data[CurrentW-1:0];
      RegSettleTicks:  cal_cfg.settle_ticks  = data[TickW-1:0];
      RegNumMotors:    cal_cfg.num_motors    = data[CountW-1:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry junk; the block must ignore them.
  task automatic apply_cfg(cfg_t c);
    wait_idle();
    write_reg(RegDriveSpeed, {1'($urandom), c.drive_speed});
    write_reg(RegCurrentLimit, c.current_limit);
    write_reg(RegSettleTicks, c.settle_ticks);
    write_reg(RegNumMotors, {13'($urandom), c.num_motors});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(cfg_t c, int unsigned n, logic with_hold);
    apply_cfg(c);
    for (int unsigned i = 0; i < n; i++) begin
      if (with_hold && i == 50) hold_asked++;
      send_item(rand_item(), 1'b0, NoWant);
    end
  endtask

  initial begin
    cfg_t        xs;
    cfg_t        nocfg;
    nocfg = '0;
    xs    = '{15'd32767, 16'd0, 16'd0, 3'd0};
    model_reset();

    // Reset settings: nothing settles within a few ticks.
    add_row(0, nocfg, CmdStart, 0, 16'd0, 32'd0, 1,
            result_t'{2'd0, 1'b1, 16'sd70, 32'sd0, 32'sd0, PhSeekHigh, 1'b0});
    add_row(0, nocfg, CmdSample, 0, 16'hFFFF, 32'h7FFFFFFF, 1,
            result_t'{2'd0, 1'b0, 16'sd0, 32'sd0, 32'sd0, PhSeekHigh, 1'b0});
    add_row(0, nocfg, CmdSample, 3, 16'd0, 32'd0, 1,
            result_t'{2'd3, 1'b0, 16'sd0, 32'sd0, 32'sd0, PhSeekHigh, 1'b0});
    add_row(0, nocfg, CmdStart, 2, 16'd0, 32'd0, 1,
            result_t'{2'd2, 1'b1, 16'sd70, 32'sd0, 32'sd0, PhSeekHigh, 1'b0});
    // Full speed, zero limit and settle; a motor count of zero is met at once.
    add_row(1, xs, CmdStart, 1, 16'd0, 32'd0, 1,
            result_t'{2'd1, 1'b1, 16'sh7FFF, 32'sd0, 32'sd0, PhSeekHigh, 1'b1});
    add_row(0, nocfg, CmdSample, 1, 16'd0, 32'd5, 0, NoWant);
    add_row(0, nocfg, CmdSample, 1, 16'hFFFF, 32'h7FFFFFFF, 1,
            result_t'{2'd1, 1'b1, 16'sd0, 32'h7FFFFFFF, 32'sd0, PhBackOff, 1'b1});
    // A stop while backing off only stops the drive.
    add_row(0, nocfg, CmdSample, 1, 16'hFFFF, 32'd0, 0, NoWant);
    add_row(0, nocfg, CmdSample, 1, 16'd0, 32'd0, 1,
            result_t'{2'd1, 1'b1, 16'h8001, 32'h7FFFFFFF, 32'sd0, PhSeekLow, 1'b1});
    add_row(0, nocfg, CmdSample, 1, 16'd0, 32'hFFFFFFFF, 0, NoWant);
    add_row(0, nocfg, CmdSample, 1, 16'd1, 32'h80000000, 1,
            result_t'{2'd1, 1'b1, 16'sd0, 32'h7FFFFFFF, 32'h80000000, PhFoundLow, 1'b1});
    // A stop in found low holds the phase for one more tick.
    xs.num_motors = 3'd1;
    add_row(1, xs, CmdSample, 1, 16'hFFFF, 32'd0, 0, NoWant);
    add_row(0, nocfg, CmdSample, 1, 16'd0, 32'd0, 1,
            result_t'{2'd1, 1'b0, 16'sd0, 32'h7FFFFFFF, 32'h80000000, PhDone, 1'b1});
    add_row(0, nocfg, CmdSample, 1, 16'hFFFF, 32'd0, 0, NoWant);
    // Restarting a finished motor keeps its stops and the finished count.
    add_row(0, nocfg, CmdStart, 1, 16'hFFFF, 32'd0, 1,
            result_t'{2'd1, 1'b1, 16'sh7FFF, 32'h7FFFFFFF, 32'h80000000, PhSeekHigh, 1'b1});
    add_row(0, nocfg, CmdSample, 0, 16'hFFFF, 32'hFFFFFFFF, 0, NoWant);
    add_row(0, nocfg, CmdSample, 3, 16'hFFFF, 32'h12345678, 0, NoWant);
    add_row(0, nocfg, CmdSample, 2, 16'd0, 32'hAAAAAAAA, 0, NoWant);
    // No current can pass the top limit; a zero speed still reverses.
    add_row(1, '{15'd0, 16'hFFFF, 16'd0, 3'd1}, CmdSample, 3, 16'hFFFF, 32'd0, 0, NoWant);
    add_row(0, nocfg, CmdStart, 2, 16'h5555, 32'h55555555, 0, NoWant);

    src_idle_pct  = 15;
    snk_stall_pct = 75;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].retune) apply_cfg(plan[i].cfg);
      send_item(plan[i].it, plan[i].typed, plan[i].want);
    end

    run_random('{15'd70, 16'd400, 16'd2, 3'd3}, 250, 1'b0);
    run_random('{15'd32767, 16'd0, 16'd0, 3'd4}, 250, 1'b1);
    src_idle_pct  = 75;
    snk_stall_pct = 15;
    run_random('{15'd0, 16'hFFFF, 16'd1, 3'd7}, 250, 1'b0);
    run_random('{15'd12345, 16'd1000, 16'd3, 3'd2}, 250, 1'b0);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    run_random('{15'($urandom), 16'($urandom_range(60000)), 16'd0, 3'd5}, 250, 1'b0);
    // A settle count near the top keeps every motor from settling.
    run_random('{15'd77, 16'd500, 16'hFFFE, 3'd4}, 250, 1'b1);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> hard_stop_joint_calibrator_core.f
hw/rtl/hsjc_pkg.sv
hw/rtl/hsjc_cfg_regs.sv
hw/rtl/hsjc_engine.sv
hw/rtl/hard_stop_joint_calibrator_core.sv
test/hard_stop_joint_calibrator_core_tb.sv
